FILE: rtl/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// constants, widths and arithmetic helpers for the fractal value noise block
// ----------------------------------------------------------------------------
package fvn_pkg;

  localparam int OCTAVES = 8;

  // base position: p0 = floor((c*256 + BP_OFFSET) / 50), done as (n>>1)*BP_RECIP >> BP_SHIFT
  localparam int          CW        = 20;
  localparam int          NW        = 31;
  localparam logic [30:0] BP_OFFSET = 31'd327680025;
  localparam int          MW        = 28;
  localparam logic [28:0] BP_RECIP  = 29'd343597384;
  localparam int          BP_SHIFT  = 33;
  localparam int          P0W       = 24;
  localparam int          BPW       = BP_SHIFT + P0W;

  // octave position, integer part and lattice hash
  localparam int          PW        = P0W + OCTAVES - 1;
  localparam logic [31:0] H_SEED    = 32'd7852;
  localparam logic [31:0] H_X       = 32'd4153;
  localparam logic [31:0] H_Y       = 32'd6534;
  localparam logic [31:0] H_MUL     = 32'd214013;
  localparam logic [31:0] H_ADD     = 32'd2531001;

  // weighted sum and normalization by 2^OCTAVES - 1
  localparam int              TW    = 17 + OCTAVES;
  localparam longint unsigned DIV   = (64'd1 << OCTAVES) - 64'd1;
  localparam int              K     = 17 + 2 * OCTAVES;
  localparam longint unsigned RECIP = ((64'd1 << K) + DIV - 64'd1) / DIV;
  localparam int              RW    = K - OCTAVES + 1;
  localparam int              QPW   = TW + RW;

  localparam int NSTAGE = 12;

  typedef logic [16:0] unit_t;

  // floor((h*65536 + 16383) / 32767) for h = d[30:16]
  function automatic unit_t corner_val(input logic [31:0] d);
    logic [16:0] h2;
    logic [16:0] t;
    unit_t       v;
    h2 = {d[30:16], 1'b0};
    t  = h2 + 17'd16383;
    if (t >= 17'd65534) begin
      v = h2 + 17'd2;
    end else if (t >= 17'd32767) begin
      v = h2 + 17'd1;
    end else begin
      v = h2;
    end
    return v;
  endfunction

  // second half of smoothstep, w2 = f*f >> 16
  function automatic unit_t smooth_fin(input logic [15:0] w2, input logic [15:0] f);
    logic [17:0] g;
    logic [33:0] p;
    g = 18'd196608 - {1'b0, f, 1'b0};
    p = 34'(w2) * 34'(g);
    return p[32:16];
  endfunction

  function automatic unit_t blend(input unit_t a, input unit_t b, input unit_t s);
    logic [33:0] p1;
    logic [33:0] p2;
    logic [34:0] sm;
    p1 = 34'(a) * 34'(17'h10000 - s);
    p2 = 34'(b) * 34'(s);
    sm = 35'(p1) + 35'(p2);
    return sm[32:16];
  endfunction

endpackage

FILE: rtl/fractal_value_noise_2d_top.sv
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_top
// eight-octave fractal value noise over a hashed 2d lattice, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   cfg_wr_en/cfg_wr_data write the 32-bit seed; write only while idle
//   input beat: in_x_coord, in_y_coord (signed q12.8) under in_valid/in_stall
//   output beat: out_noise_value (unsigned q0.16) under out_valid/out_stall
//   one output beat per input beat, in order
// timing
//   12 register stages from input to output register; with no stall,
//   one beat per cycle sustained; all octaves run as parallel lanes, each
//   stage has at most one multiplier on its path
// reset
//   rst_n low clears all stage valid bits and sets the seed to 0
// stall
//   each stage loads when it is empty or the next stage moves, so bubbles
//   are squeezed out; in_stall rises only when every stage holds a beat
//   and out_stall is high
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_top
  import fvn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic signed [31:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [19:0]  in_x_coord,
  input  logic signed [19:0]  in_y_coord,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_noise_value
);

  logic [31:0]      seedk_r;
  logic [NSTAGE:1]  vld_r;
  logic [NSTAGE+1:1] en;

  logic [BPW-1:0] prodx_r, prody_r;
  logic [P0W-1:0] p0x_r, p0y_r;

  logic [31:0] ax0_r [OCTAVES];
  logic [31:0] ax1_r [OCTAVES];
  logic [31:0] sq0_r [OCTAVES];
  logic [31:0] sq1_r [OCTAVES];
  logic [15:0] w2x_r [OCTAVES];
  logic [15:0] w2y_r [OCTAVES];
  logic [15:0] fx_r  [OCTAVES];
  logic [15:0] fy_r  [OCTAVES];

  logic [31:0] bx0_r [OCTAVES];
  logic [31:0] bx1_r [OCTAVES];
  logic [31:0] by0_r [OCTAVES];
  logic [31:0] by1_r [OCTAVES];
  unit_t       sx4_r [OCTAVES];
  unit_t       sy4_r [OCTAVES];

  logic [31:0] e00_r [OCTAVES];
  logic [31:0] e10_r [OCTAVES];
  logic [31:0] e01_r [OCTAVES];
  logic [31:0] e11_r [OCTAVES];
  unit_t       sx5_r [OCTAVES];
  unit_t       sy5_r [OCTAVES];

  logic [31:0] d00_r [OCTAVES];
  logic [31:0] d10_r [OCTAVES];
  logic [31:0] d01_r [OCTAVES];
  logic [31:0] d11_r [OCTAVES];
  unit_t       sx6_r [OCTAVES];
  unit_t       sy6_r [OCTAVES];

  unit_t       v00_r [OCTAVES];
  unit_t       v10_r [OCTAVES];
  unit_t       v01_r [OCTAVES];
  unit_t       v11_r [OCTAVES];
  unit_t       sx7_r [OCTAVES];
  unit_t       sy7_r [OCTAVES];

  unit_t       lo_r  [OCTAVES];
  unit_t       hi_r  [OCTAVES];
  unit_t       sy8_r [OCTAVES];

  unit_t       n_r   [OCTAVES];

  logic [TW-1:0]  total_r;
  logic [TW-1:0]  total_nxt;
  logic [QPW-1:0] qp_r;
  logic [QPW-K-1:0] q;
  logic [15:0]    noise_value_r;

  logic [NW-1:0] nx, ny;
  logic [MW-1:0] mx, my;

  // stage enables, from the output back
  always_comb begin
    en[NSTAGE+1] = !out_stall;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall        = !en[1];
  assign out_valid       = vld_r[NSTAGE];
  assign out_noise_value = noise_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seedk_r <= '0;
    end else if (cfg_wr_en) begin
      seedk_r <= cfg_wr_data * H_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // base position
  always_comb begin
    nx = {{(NW-CW){in_x_coord[CW-1]}}, in_x_coord} << 8;
    ny = {{(NW-CW){in_y_coord[CW-1]}}, in_y_coord} << 8;
    nx = nx + BP_OFFSET;
    ny = ny + BP_OFFSET;
    mx = nx[MW:1];
    my = ny[MW:1];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prodx_r <= BPW'(mx) * BPW'(BP_RECIP);
      prody_r <= BPW'(my) * BPW'(BP_RECIP);
    end
    if (en[2]) begin
      p0x_r <= prodx_r[BP_SHIFT +: P0W];
      p0y_r <= prody_r[BP_SHIFT +: P0W];
    end
  end

  // octave lanes
  always_ff @(posedge clk) begin
    logic [PW-1:0] px, py;
    logic [31:0]   ix, iy, iy1;
    logic [31:0]   fxsq, fysq;
    for (int i = 0; i < OCTAVES; i++) begin
      px   = PW'(p0x_r) << i;
      py   = PW'(p0y_r) << i;
      ix   = 32'(px[PW-1:16]);
      iy   = 32'(py[PW-1:16]);
      iy1  = iy + 32'd1;
      fxsq = 32'(px[15:0]) * 32'(px[15:0]);
      fysq = 32'(py[15:0]) * 32'(py[15:0]);
      if (en[3]) begin
        ax0_r[i] <= ix * H_X;
        ax1_r[i] <= (ix + 32'd1) * H_X;
        sq0_r[i] <= iy * iy;
        sq1_r[i] <= iy1 * iy1;
        w2x_r[i] <= fxsq[31:16];
        w2y_r[i] <= fysq[31:16];
        fx_r[i]  <= px[15:0];
        fy_r[i]  <= py[15:0];
      end
      if (en[4]) begin
        bx0_r[i] <= ax0_r[i];
        bx1_r[i] <= ax1_r[i];
        by0_r[i] <= sq0_r[i] * H_Y;
        by1_r[i] <= sq1_r[i] * H_Y;
        sx4_r[i] <= smooth_fin(w2x_r[i], fx_r[i]);
        sy4_r[i] <= smooth_fin(w2y_r[i], fy_r[i]);
      end
      if (en[5]) begin
        e00_r[i] <= seedk_r + bx0_r[i] + by0_r[i];
        e10_r[i] <= seedk_r + bx1_r[i] + by0_r[i];
        e01_r[i] <= seedk_r + bx0_r[i] + by1_r[i];
        e11_r[i] <= seedk_r + bx1_r[i] + by1_r[i];
        sx5_r[i] <= sx4_r[i];
        sy5_r[i] <= sy4_r[i];
      end
      if (en[6]) begin
        d00_r[i] <= e00_r[i] * H_MUL + H_ADD;
        d10_r[i] <= e10_r[i] * H_MUL + H_ADD;
        d01_r[i] <= e01_r[i] * H_MUL + H_ADD;
        d11_r[i] <= e11_r[i] * H_MUL + H_ADD;
        sx6_r[i] <= sx5_r[i];
        sy6_r[i] <= sy5_r[i];
      end
      if (en[7]) begin
        v00_r[i] <= corner_val(d00_r[i]);
        v10_r[i] <= corner_val(d10_r[i]);
        v01_r[i] <= corner_val(d01_r[i]);
        v11_r[i] <= corner_val(d11_r[i]);
        sx7_r[i] <= sx6_r[i];
        sy7_r[i] <= sy6_r[i];
      end
      if (en[8]) begin
        lo_r[i]  <= blend(v00_r[i], v10_r[i], sx7_r[i]);
        hi_r[i]  <= blend(v01_r[i], v11_r[i], sx7_r[i]);
        sy8_r[i] <= sy7_r[i];
      end
      if (en[9]) begin
        n_r[i] <= blend(lo_r[i], hi_r[i], sy8_r[i]);
      end
    end
  end

  // weighted octave sum
  always_comb begin
    total_nxt = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      total_nxt = total_nxt + (TW'(n_r[i]) << (OCTAVES - 1 - i));
    end
  end

  assign q = qp_r[QPW-1:K];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      total_r <= total_nxt;
    end
    if (en[11]) begin
      qp_r <= QPW'(total_r + TW'(DIV >> 1)) * QPW'(RECIP);
    end
    if (en[12]) begin
      noise_value_r <= (q > (QPW-K)'(16'hFFFF)) ? 16'hFFFF : q[15:0];
    end
  end

endmodule

FILE: rtl/fvn_check.sv
// ----------------------------------------------------------------------------
// fvn_check
// port-level checks for the fractal value noise block, bound to the top level
// ----------------------------------------------------------------------------
module fvn_check
  import fvn_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_noise_value
);

  // held output beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("output beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input backpressure only comes from output backpressure
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // input is refused only while an output beat is held
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");

endmodule

bind fractal_value_noise_2d_top fvn_check u_fvn_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);
